@@ design/ssm_pkg.sv @@
// Shared types and constants of the striped volume sector mapper.
// Used by every module of the block; depends on nothing.
package ssm_pkg;

    localparam int SECTOR_W   = 64;
    localparam int IDX_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int SHIFT_W    = 5;
    localparam int LOW_W      = 31;
    localparam int MEMBERS    = 16;
    localparam logic [COUNT_W-1:0] MAX_MEMBERS = 5'd16;

    localparam int DIGIT_W    = 4;
    localparam int DIV_STAGES = SECTOR_W / DIGIT_W;

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_FIRST = 2'd2;

    localparam logic ACT_MAP  = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0]  member_count;
        logic [SHIFT_W-1:0]  chunk_log2;
        logic [SECTOR_W-1:0] volume_first_sector;
    } cfg_t;

    // word: chunk number (map) or start sector (load); idx: remainder or member index
    typedef struct packed {
        logic                is_load;
        logic [SECTOR_W-1:0] word;
        logic [LOW_W-1:0]    low;
        logic [IDX_W-1:0]    idx;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]    dev;
        logic [SECTOR_W-1:0] phys;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ design/ssm_front.sv @@
// Front end: takes requests; for maps it subtracts the volume start and splits the
// offset into chunk number and in-chunk offset. Depends on ssm_pkg.
module ssm_front
    import ssm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                push,
    input  logic                action,
    input  logic [SECTOR_W-1:0] logical_sector,
    input  logic [IDX_W-1:0]    member_index,
    input  logic [SECTOR_W-1:0] member_start,
    output logic                full,
    input  q_stat_t             q_stat,
    output logic                q_wr_en,
    output item_t               q_wr_data
);

    logic                fv_reg;
    logic                f_load_reg;
    logic [SECTOR_W-1:0] f_word_reg;
    logic [IDX_W-1:0]    f_idx_reg;
    logic                accept;
    logic [LOW_W-1:0]    low_mask;

    assign q_wr_en = fv_reg && !q_stat.full;
    assign full    = fv_reg && q_stat.full;
    assign accept  = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (accept)
        begin
            fv_reg <= 1'b1;
        end
        else if (q_wr_en)
        begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_load_reg <= (action == ACT_LOAD);
            if (action == ACT_LOAD)
            begin
                f_word_reg <= member_start;
                f_idx_reg  <= member_index;
            end
            else
            begin
                f_word_reg <= logical_sector - cfg.volume_first_sector;
                f_idx_reg  <= '0;
            end
        end
    end

    assign low_mask = (LOW_W'(1) << cfg.chunk_log2) - LOW_W'(1);

    always_comb
    begin
        q_wr_data.is_load = f_load_reg;
        q_wr_data.idx     = f_idx_reg;
        if (f_load_reg)
        begin
            q_wr_data.word = f_word_reg;
            q_wr_data.low  = '0;
        end
        else
        begin
            q_wr_data.word = f_word_reg >> cfg.chunk_log2;
            q_wr_data.low  = f_word_reg[LOW_W-1:0] & low_mask;
        end
    end

endmodule

@@ design/ssm_queue.sv @@
// Short request queue between front and back end.
// Depends on ssm_pkg.
module ssm_queue
    import ssm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  item_t   wr_data,
    input  logic    rd_en,
    output item_t   rd_data,
    output q_stat_t stat
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

@@ design/ssm_outq.sv @@
// Result queue at the output of the back end.
// Depends on ssm_pkg.
module ssm_outq
    import ssm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    input  logic    rd_en,
    output result_t rd_data,
    output q_stat_t stat
);

    result_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

@@ design/ssm_back.sv @@
// Back end: pipelined divide by member count (4 quotient bits per stage),
// member start table and final address add. Depends on ssm_pkg.
module ssm_back
    import ssm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   q_head,
    input  q_stat_t q_stat,
    output logic    q_rd_en,
    input  logic    oq_full,
    output logic    res_push,
    output result_t res_data
);

    function automatic logic [IDX_W+DIGIT_W-1:0] div_digit(
        input logic [IDX_W-1:0]   rem_in,
        input logic [DIGIT_W-1:0] bits,
        input logic [COUNT_W-1:0] n
    );
        logic [COUNT_W-1:0] r;
        logic [DIGIT_W-1:0] q;
        r = {1'b0, rem_in};
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            r = {r[IDX_W-1:0], bits[i]};
            if (r >= n)
            begin
                r    = r - n;
                q[i] = 1'b1;
            end
            else
            begin
                q[i] = 1'b0;
            end
        end
        return {r[IDX_W-1:0], q};
    endfunction

    logic [COUNT_W-1:0]    eff_n;
    logic                  advance;
    logic [DIV_STAGES-1:0] dv_reg;
    logic [DIV_STAGES-1:0] dv_next;
    item_t                 ds_reg  [DIV_STAGES];
    item_t                 ds_in   [DIV_STAGES];
    item_t                 ds_next [DIV_STAGES];
    item_t                 last;
    logic                  last_v;

    logic [SECTOR_W-1:0]   start_mem [MEMBERS];
    logic                  rv_reg;
    logic                  r_map_reg;
    logic [IDX_W-1:0]      r_dev_reg;
    logic [SECTOR_W-1:0]   r_qlow_reg;
    logic [SECTOR_W-1:0]   r_start_reg;
    logic [SECTOR_W-1:0]   qlow_next;

    always_comb
    begin
        if (cfg.member_count == '0)
        begin
            eff_n = COUNT_W'(1);
        end
        else if (cfg.member_count > MAX_MEMBERS)
        begin
            eff_n = MAX_MEMBERS;
        end
        else
        begin
            eff_n = cfg.member_count;
        end
    end

    assign advance = !(rv_reg && r_map_reg && oq_full);
    assign q_rd_en = advance && !q_stat.empty;

    always_comb
    begin
        ds_in[0] = q_head;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            ds_in[k] = ds_reg[k-1];
        end
    end

    always_comb
    begin
        logic [IDX_W+DIGIT_W-1:0] d;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            ds_next[k] = ds_in[k];
            d = div_digit(ds_in[k].idx,
                          ds_in[k].word[SECTOR_W-1-DIGIT_W*k -: DIGIT_W], eff_n);
            if (!ds_in[k].is_load)
            begin
                ds_next[k].idx = d[IDX_W+DIGIT_W-1:DIGIT_W];
                ds_next[k].word[SECTOR_W-1-DIGIT_W*k -: DIGIT_W] = d[DIGIT_W-1:0];
            end
        end
    end

    assign dv_next = {dv_reg[DIV_STAGES-2:0], q_rd_en};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else if (advance)
        begin
            dv_reg <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                ds_reg[k] <= ds_next[k];
            end
        end
    end

    // quotient shifted back; its low bits are zero, so the offset ORs in
    assign last      = ds_reg[DIV_STAGES-1];
    assign last_v    = dv_reg[DIV_STAGES-1];
    assign qlow_next = (last.word << cfg.chunk_log2)
                     | {{(SECTOR_W-LOW_W){1'b0}}, last.low};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg    <= 1'b0;
            r_map_reg <= 1'b0;
        end
        else if (advance)
        begin
            rv_reg    <= last_v;
            r_map_reg <= !last.is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_dev_reg  <= last.idx;
            r_qlow_reg <= qlow_next;
            if (last_v)
            begin
                if (last.is_load)
                begin
                    start_mem[last.idx] <= last.word;
                end
                else
                begin
                    r_start_reg <= start_mem[last.idx];
                end
            end
        end
    end

    assign res_push      = advance && rv_reg && r_map_reg;
    assign res_data.dev  = r_dev_reg;
    assign res_data.phys = r_start_reg + r_qlow_reg;

endmodule

@@ design/stripe_sector_mapper.sv @@
// Striped (RAID0) volume sector mapper: top level with configuration registers.
// Depends on ssm_pkg, ssm_front, ssm_queue, ssm_back, ssm_outq.
//
// Load requests (action 1) write one member's start sector; map requests
// (action 0) return the member device and physical sector of a logical
// sector. One request is taken per cycle when neither queue backs up. A map
// result reaches the result ports by way of the front stage, the request
// queue write, the 16-stage divide-by-member-count pipeline, the start-table
// read stage and the result queue write. Loads and maps are processed in
// order, so a map sees every load issued before it. A map must only select
// members whose start has been loaded. Write configuration only while no
// request is in flight.
module stripe_sector_mapper
    import ssm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 action,
    input  logic [SECTOR_W-1:0]  logical_sector,
    input  logic [IDX_W-1:0]     member_index,
    input  logic [SECTOR_W-1:0]  member_start,
    output logic                 empty,
    input  logic                 pop,
    output logic [IDX_W-1:0]     device_index,
    output logic [SECTOR_W-1:0]  physical_sector,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SECTOR_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    logic    q_wr_en;
    item_t   q_wr_data;
    logic    q_rd_en;
    item_t   q_head;
    q_stat_t q_stat;
    logic    res_push;
    result_t res_data;
    result_t oq_head;
    q_stat_t oq_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.member_count        <= COUNT_W'(1);
            cfg_reg.chunk_log2          <= SHIFT_W'(3);
            cfg_reg.volume_first_sector <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEMBER_COUNT: cfg_reg.member_count        <= cfg_data[COUNT_W-1:0];
                REG_CHUNK_LOG2:   cfg_reg.chunk_log2          <= cfg_data[SHIFT_W-1:0];
                REG_VOLUME_FIRST: cfg_reg.volume_first_sector <= cfg_data;
                default:          ;
            endcase
        end
    end

    ssm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .push           (push),
        .action         (action),
        .logical_sector (logical_sector),
        .member_index   (member_index),
        .member_start   (member_start),
        .full           (full),
        .q_stat         (q_stat),
        .q_wr_en        (q_wr_en),
        .q_wr_data      (q_wr_data)
    );

    ssm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_head),
        .stat    (q_stat)
    );

    ssm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_rd_en  (q_rd_en),
        .oq_full  (oq_stat.full),
        .res_push (res_push),
        .res_data (res_data)
    );

    ssm_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .rd_en   (pop && !oq_stat.empty),
        .rd_data (oq_head),
        .stat    (oq_stat)
    );

    assign empty           = oq_stat.empty;
    assign device_index    = oq_head.dev;
    assign physical_sector = oq_head.phys;

`ifndef SYNTH
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("request queue full and empty together");

    a_full_source: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_stat.full)
        else $error("full raised while request queue has room");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !oq_stat.full)
        else $error("result pushed into full result queue");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost without pop");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking bench for stripe_sector_mapper: directed table, then randomized phases
// under several register settings, checked against table values and an in-bench striping predictor.
// Depends on ssm_pkg and the stripe_sector_mapper RTL.
module tb;
    import ssm_pkg::*;

    localparam int DRAIN     = 40;
    localparam int LIMIT     = 3000;
    localparam int HOLD_LEN  = 300;
    localparam int NPH       = 6;
    localparam int PER_PHASE = 92;
    localparam int DIR_ROWS  = 26;
    localparam logic [SECTOR_W-1:0] ALL1 = {SECTOR_W{1'b1}};

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                act;
        logic [SECTOR_W-1:0] sector;
        logic [IDX_W-1:0]    idx;
        logic [SECTOR_W-1:0] start;
        logic [COUNT_W-1:0]  cnt;
        logic [SHIFT_W-1:0]  shf;
        bit                  typed;
        logic [IDX_W-1:0]    edev;
        logic [SECTOR_W-1:0] ephys;
    } row_t;

    // sector field doubles as volume_first_sector on register rows
    row_t dir_tab [DIR_ROWS] = '{
        '{ROW_REQ, ACT_LOAD, 64'h0, 4'd0, 64'h0, 5'd0, 5'd0, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h0, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, ALL1, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd0, ALL1},
        '{ROW_REQ, ACT_LOAD, 64'h0, 4'd0, ALL1, 5'd0, 5'd0, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h1, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd0, 64'h0},
        '{ROW_REQ, ACT_LOAD, ALL1, 4'd15, 64'h1000, 5'd0, 5'd0, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h123, 4'd15, ALL1, 5'd0, 5'd0, 1'b1, 4'd0, 64'h122},
        '{ROW_CFG, ACT_MAP, 64'h0, 4'd0, 64'h0, 5'd0, 5'd3, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h123, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd0, 64'h122},
        '{ROW_CFG, ACT_MAP, 64'h0, 4'd0, 64'h0, 5'd16, 5'd31, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h7_8000_0000, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd15, 64'h1000},
        '{ROW_CFG, ACT_MAP, 64'h0, 4'd0, 64'h0, 5'd31, 5'd31, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h7_8000_0005, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd15, 64'h1005},
        '{ROW_REQ, ACT_MAP, 64'h8_0000_0000, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd0,
          64'h7fff_ffff},
        '{ROW_REQ, ACT_LOAD, 64'h0, 4'd1, 64'h5, 5'd0, 5'd0, 1'b0, 4'd0, 64'h0},
        '{ROW_CFG, ACT_MAP, ALL1, 4'd0, 64'h0, 5'd2, 5'd0, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h0, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd1, 64'h5},
        '{ROW_REQ, ACT_MAP, ALL1, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd0, ALL1},
        '{ROW_REQ, ACT_MAP, 64'h8000_0000_0000_0001, 4'd0, 64'h0, 5'd0, 5'd0, 1'b0, 4'd0,
          64'h0},
        '{ROW_REQ, ACT_LOAD, 64'h0, 4'd2, 64'h0123_4567_89ab_cdef, 5'd0, 5'd0, 1'b0, 4'd0,
          64'h0},
        '{ROW_CFG, ACT_MAP, 64'd100, 4'd0, 64'h0, 5'd3, 5'd5, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'hdead_beef_0000_1234, 4'd0, 64'h0, 5'd0, 5'd0, 1'b0, 4'd0,
          64'h0},
        '{ROW_REQ, ACT_MAP, 64'd99, 4'd0, 64'h0, 5'd0, 5'd0, 1'b0, 4'd0, 64'h0},
        '{ROW_CFG, ACT_MAP, 64'h0, 4'd0, 64'h0, 5'd16, 5'd2, 1'b0, 4'd0, 64'h0},
        '{ROW_REQ, ACT_MAP, 64'h3, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd0, 64'h2},
        '{ROW_REQ, ACT_MAP, 64'h3c, 4'd0, 64'h0, 5'd0, 5'd0, 1'b1, 4'd15, 64'h1000}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 action;
    logic [SECTOR_W-1:0]  logical_sector;
    logic [IDX_W-1:0]     member_index;
    logic [SECTOR_W-1:0]  member_start;
    logic                 empty;
    logic                 pop;
    logic [IDX_W-1:0]     device_index;
    logic [SECTOR_W-1:0]  physical_sector;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SECTOR_W-1:0]  cfg_data;

    logic [COUNT_W-1:0]   cfg_count;
    logic [SHIFT_W-1:0]   cfg_shift;
    logic [SECTOR_W-1:0]  cfg_first;
    logic [SECTOR_W-1:0]  start_tbl [MEMBERS];
    bit                   start_set [MEMBERS];
    result_t              pending_maps [$];

    bit gaps_on;
    bit calm;
    bit hold_go;
    bit hold_done;
    int hold_left;
    int stall;
    int mismatches;
    int n_maps;
    int n_loads;
    int n_checked;
    int n_settings;

    stripe_sector_mapper uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .logical_sector  (logical_sector),
        .member_index    (member_index),
        .member_start    (member_start),
        .empty           (empty),
        .pop             (pop),
        .device_index    (device_index),
        .physical_sector (physical_sector),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [SECTOR_W-1:0] rand_sector();
        return {$urandom, $urandom};
    endfunction

    function automatic result_t map_sector(input logic [SECTOR_W-1:0] sector);
        logic [SECTOR_W-1:0] off;
        logic [SECTOR_W-1:0] chunk;
        logic [SECTOR_W-1:0] n;
        logic [SECTOR_W-1:0] quot;
        logic [SECTOR_W-1:0] mask;
        result_t r;
        off = sector - cfg_first;
        chunk = off >> cfg_shift;
        if (cfg_count == '0)
            n = 64'd1;
        else if (cfg_count > MAX_MEMBERS)
            n = 64'(MEMBERS);
        else
            n = 64'(cfg_count);
        r.dev = IDX_W'(chunk % n);
        quot = chunk / n;
        mask = (64'd1 << cfg_shift) - 64'd1;
        r.phys = start_tbl[r.dev] + (quot << cfg_shift) + (off & mask);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [SECTOR_W-1:0] got,
                                   input logic [SECTOR_W-1:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic drive_item(input logic act, input logic [SECTOR_W-1:0] sector,
                              input logic [IDX_W-1:0] idx, input logic [SECTOR_W-1:0] start);
        while (gaps_on && $urandom_range(99) < 10)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        action         <= act;
        logical_sector <= sector;
        member_index   <= idx;
        member_start   <= start;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic apply_load(input logic [IDX_W-1:0] idx, input logic [SECTOR_W-1:0] start,
                              input logic [SECTOR_W-1:0] junk);
        drive_item(ACT_LOAD, junk, idx, start);
        start_tbl[idx] = start;
        start_set[idx] = 1'b1;
        n_loads++;
    endtask

    task automatic send_request(input logic act, input logic [SECTOR_W-1:0] sector,
                                input logic [IDX_W-1:0] idx, input logic [SECTOR_W-1:0] start,
                                input bit typed, input result_t want);
        result_t r;
        if (act == ACT_LOAD)
            apply_load(idx, start, sector);
        else
        begin
            r = map_sector(sector);
            // never map onto a member that has no start loaded yet
            if (!start_set[r.dev])
                apply_load(r.dev, rand_sector(), rand_sector());
            drive_item(ACT_MAP, sector, idx, start);
            r = typed ? want : map_sector(sector);
            pending_maps.push_back(r);
            n_maps++;
        end
    endtask

    task automatic set_config(input logic [COUNT_W-1:0] cnt, input logic [SHIFT_W-1:0] shf,
                              input logic [SECTOR_W-1:0] first);
        push <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MEMBER_COUNT;
        cfg_data  <= SECTOR_W'(cnt);
        @(posedge clk);
        cfg_index <= REG_CHUNK_LOG2;
        cfg_data  <= SECTOR_W'(shf);
        @(posedge clk);
        cfg_index <= REG_VOLUME_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_count = cnt;
        cfg_shift = shf;
        cfg_first = first;
        n_settings++;
    endtask

    // result side: random or steady pops, one long hold-off, in-order compare
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_maps.size() == 0)
                    report_mismatch("result with nothing pending", physical_sector, '0);
                else
                begin
                    result_t want;
                    want = pending_maps.pop_front();
                    if (device_index !== want.dev)
                        report_mismatch("device_index", SECTOR_W'(device_index),
                                        SECTOR_W'(want.dev));
                    if (physical_sector !== want.phys)
                        report_mismatch("physical_sector", physical_sector, want.phys);
                    n_checked++;
                end
            end
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (calm)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall = 0;
        else
            stall++;
        if (stall >= LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [SECTOR_W-1:0] sector;
        result_t want;
        rst_n          = 1'b0;
        push           = 1'b0;
        action         = ACT_MAP;
        logical_sector = '0;
        member_index   = '0;
        member_start   = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_MEMBER_COUNT;
        cfg_data       = '0;
        cfg_count      = 5'd1;
        cfg_shift      = 5'd3;
        cfg_first      = '0;
        for (int i = 0; i < MEMBERS; i++)
        begin
            start_tbl[i] = '0;
            start_set[i] = 1'b0;
        end
        gaps_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                set_config(dir_tab[i].cnt, dir_tab[i].shf, dir_tab[i].sector);
            else
            begin
                want.dev  = dir_tab[i].edev;
                want.phys = dir_tab[i].ephys;
                send_request(dir_tab[i].act, dir_tab[i].sector, dir_tab[i].idx,
                             dir_tab[i].start, dir_tab[i].typed, want);
            end
        end

        for (int p = 0; p < NPH; p++)
        begin
            case (p)
                0: set_config(5'd16, 5'd3, '0);
                1: set_config(5'd31, 5'd31, ALL1);
                2: set_config(5'd0, 5'd0, rand_sector());
                3: set_config(5'd1, 5'd31, '0);
                default: set_config(5'($urandom_range(31)), 5'($urandom_range(31)),
                                    rand_sector());
            endcase
            calm    = (p == 2);
            gaps_on = (p != 2);
            if (p == 3)
                hold_go = 1'b1;
            for (int k = 0; k < PER_PHASE; k++)
            begin
                if ($urandom_range(99) < 20)
                    send_request(ACT_LOAD, rand_sector(), 4'($urandom_range(15)),
                                 ($urandom_range(9) == 0) ? ALL1 : rand_sector(), 1'b0, want);
                else
                begin
                    case ($urandom_range(3))
                        0: sector = rand_sector();
                        1: sector = cfg_first + 64'($urandom_range(4095));
                        2:
                        begin
                            case ($urandom_range(3))
                                0: sector = '0;
                                1: sector = ALL1;
                                2: sector = cfg_first;
                                default: sector = cfg_first - 64'd1;
                            endcase
                        end
                        default: sector = cfg_first + (64'($urandom_range(255)) << cfg_shift)
                                          + (rand_sector() & ((64'd1 << cfg_shift) - 64'd1));
                    endcase
                    send_request(ACT_MAP, sector, 4'($urandom_range(15)), rand_sector(),
                                 1'b0, want);
                end
            end
        end

        push <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("Run covered %0d map and %0d load requests under %0d register settings,",
                 n_maps, n_loads, n_settings);
        $display("with %0d results compared and %0d mismatches.", n_checked, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
